[src/ard_pkg.sv]
// Shared types, constants and character codes for the AT response deframer.
package ard_pkg;

  // Width of the HTTP length and byte counters.
  localparam int unsigned HttpLenBits = 24;
  // Width of the byte position field in a result.
  localparam int unsigned ByteIdxW    = 24;

  // Character codes that the framing logic looks for.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Input item commands.
  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_ARM_I2C  = 2'd1,
    CMD_ARM_HTTP = 2'd2
  } cmd_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_I2C  = 2'd0,
    KIND_HTTP = 2'd1,
    KIND_ECHO = 2'd2
  } kind_t;

  // I2C response hunt phases; the eight match phases walk "DRVI2CRD".
  typedef enum logic [3:0] {
    I2C_DISCARD  = 4'd0,
    I2C_MATCH_D  = 4'd1,
    I2C_MATCH_R  = 4'd2,
    I2C_MATCH_V  = 4'd3,
    I2C_MATCH_I  = 4'd4,
    I2C_MATCH_2  = 4'd5,
    I2C_MATCH_C  = 4'd6,
    I2C_MATCH_R2 = 4'd7,
    I2C_MATCH_D2 = 4'd8,
    I2C_COLON    = 4'd9,
    I2C_DATA     = 4'd10
  } i2c_phase_t;

  // HTTP response phases.
  typedef enum logic [1:0] {
    HTTP_EMPTY = 2'd0,
    HTTP_COLON = 2'd1,
    HTTP_COMMA = 2'd2,
    HTTP_DATA  = 2'd3
  } http_phase_t;

  // One input item.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] i2c_length;
  } item_t;

  // One result item.
  typedef struct packed {
    kind_t                kind;
    logic [7:0]           out_byte;
    logic [ByteIdxW-1:0]  byte_index;
    logic                 last;
  } res_t;

  // Deframer state carried from item to item.
  typedef struct packed {
    logic [7:0]             prev_byte;
    logic                   i2c_pending;
    i2c_phase_t             i2c_phase;
    logic [7:0]             i2c_expected;
    logic [7:0]             i2c_count;
    logic                   http_pending;
    http_phase_t            http_phase;
    logic [HttpLenBits-1:0] http_length;
    logic                   http_digits_done;
    logic [HttpLenBits-1:0] http_count;
  } ard_state_t;

  // Character expected in a given match phase.
  function automatic logic [7:0] i2c_word_char(input i2c_phase_t ph);
    logic [7:0] c;
    case (ph)
      I2C_MATCH_D:  c = CH_D;
      I2C_MATCH_R:  c = CH_R;
      I2C_MATCH_V:  c = CH_V;
      I2C_MATCH_I:  c = CH_I;
      I2C_MATCH_2:  c = CH_TWO;
      I2C_MATCH_C:  c = CH_C;
      I2C_MATCH_R2: c = CH_R;
      I2C_MATCH_D2: c = CH_D;
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[src/at_response_deframer_core.sv]
// Top level of the AT response deframer: handshakes, item and result registers.
//
// The deframer takes one item per clock cycle while its results are taken. An
// input transfer loads the item register, and the item's result moves into the
// result register once that register is empty or being drained. Modem bytes are
// echoed, dropped or streamed out as I2C or HTTP data depending on the armed
// query, at most one result per item. in_tready is high while the item register
// is empty or its item moves on in the same cycle, which it does whenever the
// result register is empty or being drained, so a waiting result blocks the
// input only once an item is also held. The echo enable register is written
// through the cfg port, which is always ready, and should only be changed while
// no items are in flight.
module at_response_deframer_core (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,      // echo_enable
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // [7:0] data_byte, [15:8] i2c_length
  input  logic [1:0]  in_tuser,      // [1:0] cmd
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [7:0] out_byte, [31:8] byte_index
  output logic [1:0]  out_tuser,     // [1:0] kind
  output logic        out_tlast      // last
);

  logic                item_valid_r;
  ard_pkg::item_t      item_r;
  logic                res_valid_r;
  ard_pkg::res_t       res_r;
  ard_pkg::ard_state_t state_r;
  ard_pkg::ard_state_t state_nxt;
  logic                echo_en_r;
  logic                step_valid;
  ard_pkg::res_t       step_res;
  logic                advance;

  // The held item moves on when the result register can take its result.
  assign advance   = item_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      echo_en_r <= cfg_data;
    end
  end

  // Item register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{cmd: in_tuser, data_byte: in_tdata[7:0], i2c_length: in_tdata[15:8]};
    end
  end

  ard_step u_step (
    .st        (state_r),
    .item      (item_r),
    .echo_en   (echo_en_r),
    .nxt       (state_nxt),
    .res_valid (step_valid),
    .res       (step_res)
  );

  // Deframer state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      res_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      res_valid_r <= step_valid;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance && step_valid) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {res_r.byte_index, res_r.out_byte};
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;

endmodule

[src/ard_step.sv]
// Next-state and result logic for one deframer item.
module ard_step (
  input  ard_pkg::ard_state_t st,
  input  ard_pkg::item_t      item,
  input  logic                echo_en,
  output ard_pkg::ard_state_t nxt,
  output logic                res_valid,
  output ard_pkg::res_t       res
);

  localparam int unsigned SumW = ard_pkg::HttpLenBits + 4;
  localparam logic [ard_pkg::HttpLenBits-1:0] LenMax = '1;

  always_comb begin
    logic                            echo;
    logic [7:0]                      b;
    logic [7:0]                      i2c_cnt1;
    logic [ard_pkg::HttpLenBits-1:0] http_cnt1;
    logic [SumW-1:0]                 sum;
    logic                            fin;

    nxt       = st;
    res_valid = 1'b0;
    echo      = 1'b0;
    b         = item.data_byte;
    i2c_cnt1  = st.i2c_count + 8'd1;
    http_cnt1 = st.http_count + ard_pkg::HttpLenBits'(1);
    fin       = 1'b0;
    // Length times ten plus the new digit, done as two shifted adds.
    sum = {1'b0, st.http_length, 3'b000} + {3'b000, st.http_length, 1'b0}
        + SumW'(b - ard_pkg::CH_ZERO);
    res = '{kind: ard_pkg::KIND_ECHO, out_byte: b, byte_index: '0, last: 1'b0};

    case (item.cmd)
      // Arming a query resets its own hunt and counters.
      ard_pkg::CMD_ARM_I2C: begin
        nxt.i2c_pending  = 1'b1;
        nxt.i2c_phase    = ard_pkg::I2C_DISCARD;
        nxt.i2c_expected = item.i2c_length;
        nxt.i2c_count    = 8'd0;
      end
      ard_pkg::CMD_ARM_HTTP: begin
        nxt.http_pending     = 1'b1;
        nxt.http_phase       = ard_pkg::HTTP_EMPTY;
        nxt.http_length      = '0;
        nxt.http_digits_done = 1'b0;
        nxt.http_count       = '0;
      end
      ard_pkg::CMD_BYTE: begin
        nxt.prev_byte = b;
        if (st.i2c_pending) begin
          // The I2C query owns the byte stream while it is pending.
          case (st.i2c_phase) inside
            ard_pkg::I2C_DATA: begin
              fin           = (i2c_cnt1 == st.i2c_expected);
              nxt.i2c_count = i2c_cnt1;
              if (fin) begin
                nxt.i2c_pending = 1'b0;
                nxt.i2c_phase   = ard_pkg::I2C_DISCARD;
              end
              res_valid = 1'b1;
              res = '{kind: ard_pkg::KIND_I2C, out_byte: b,
                      byte_index: ard_pkg::ByteIdxW'(st.i2c_count), last: fin};
            end
            ard_pkg::I2C_COLON: begin
              if (b == ard_pkg::CH_COLON) begin
                nxt.i2c_count = 8'd0;
                nxt.i2c_phase = ard_pkg::I2C_DATA;
              end else begin
                nxt.i2c_phase = ard_pkg::I2C_DISCARD;
                echo          = 1'b1;
              end
            end
            [ard_pkg::I2C_MATCH_D:ard_pkg::I2C_MATCH_D2]: begin
              if (b == ard_pkg::i2c_word_char(st.i2c_phase)) begin
                nxt.i2c_phase = ard_pkg::i2c_phase_t'(st.i2c_phase + 4'd1);
                // The 'R' right after the 'D' is passed on as echo.
                echo = (st.i2c_phase == ard_pkg::I2C_MATCH_R);
              end else begin
                nxt.i2c_phase = ard_pkg::I2C_DISCARD;
                echo          = 1'b1;
              end
            end
            default: begin
              // Discard phase: a '+' not preceded by 'T' opens the hunt.
              if (b == ard_pkg::CH_PLUS && st.prev_byte != ard_pkg::CH_T) begin
                nxt.i2c_phase = ard_pkg::I2C_MATCH_D;
              end else begin
                nxt.i2c_phase = ard_pkg::I2C_DISCARD;
                echo          = 1'b1;
              end
            end
          endcase
        end else if (st.http_pending) begin
          case (st.http_phase)
            ard_pkg::HTTP_EMPTY: begin
              if (b == ard_pkg::CH_PLUS && st.prev_byte != ard_pkg::CH_T) begin
                nxt.http_phase = ard_pkg::HTTP_COLON;
              end else begin
                echo = 1'b1;
              end
            end
            ard_pkg::HTTP_COLON: begin
              if (b == ard_pkg::CH_COLON) begin
                nxt.http_phase = ard_pkg::HTTP_COMMA;
              end
            end
            ard_pkg::HTTP_COMMA: begin
              if (b == ard_pkg::CH_COMMA) begin
                if (st.http_length == '0) begin
                  // An empty body ends the query at the comma.
                  nxt.http_pending     = 1'b0;
                  nxt.http_phase       = ard_pkg::HTTP_EMPTY;
                  nxt.http_digits_done = 1'b0;
                  nxt.http_count       = '0;
                end else begin
                  nxt.http_phase = ard_pkg::HTTP_DATA;
                  nxt.http_count = '0;
                end
              end else if (!st.http_digits_done &&
                           b inside {[ard_pkg::CH_ZERO:ard_pkg::CH_NINE]}) begin
                // Saturate the length at the counter's full scale.
                if (sum > SumW'(LenMax)) begin
                  nxt.http_length = LenMax;
                end else begin
                  nxt.http_length = sum[ard_pkg::HttpLenBits-1:0];
                end
              end else begin
                nxt.http_digits_done = 1'b1;
              end
            end
            default: begin
              fin            = (http_cnt1 == st.http_length);
              nxt.http_count = http_cnt1;
              if (fin) begin
                nxt.http_pending     = 1'b0;
                nxt.http_phase       = ard_pkg::HTTP_EMPTY;
                nxt.http_length      = '0;
                nxt.http_digits_done = 1'b0;
                nxt.http_count       = '0;
              end
              res_valid = 1'b1;
              res = '{kind: ard_pkg::KIND_HTTP, out_byte: b,
                      byte_index: ard_pkg::ByteIdxW'(st.http_count), last: fin};
            end
          endcase
        end else begin
          // Idle: everything but a form feed is echo.
          echo = (b != ard_pkg::CH_FF);
        end
      end
      default: begin
        // Unused command code: no state change, no result.
      end
    endcase

    if (echo && echo_en) begin
      res_valid = 1'b1;
    end
  end

endmodule

[src/ard_checker.sv]
// Port-level checks for the AT response deframer, bound to the top level.
module ard_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // A stalled result holds until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // An echo carries no position and never closes a frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ard_pkg::KIND_ECHO |->
      out_tdata[31:8] == 24'd0 && !out_tlast)
    else $error("echo result with position or last");

  // Reset drops any pending result.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The position of the final I2C data byte fits in the eight-bit counter.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == ard_pkg::KIND_I2C && out_tlast
      |-> out_tdata[31:16] == 16'd0)
    else $error("I2C position beyond eight bits");

endmodule

bind at_response_deframer_core ard_checker u_ard_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/tb_at_response_deframer_core.sv]
// Self-checking testbench for the AT response deframer core.
`timescale 1ns / 1ps

module tb_at_response_deframer_core;
  import ard_pkg::*;

  // Command code that the deframer has no use for.
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  localparam int TotalItems   = 800;
  localparam int SettleCycles = 6;
  localparam int StuckLimit   = 2000;
  localparam logic [HttpLenBits-1:0] LenMax = '1;

  // Tracks the deframer state and the results it owes.
  class deframer_scoreboard;
    logic                   echo_on;
    logic [7:0]             prev_rx;
    logic                   i2c_armed;
    i2c_phase_t             i2c_ph;
    logic [7:0]             i2c_want;
    logic [7:0]             i2c_seen;
    logic                   http_armed;
    http_phase_t            http_ph;
    logic [HttpLenBits-1:0] http_len;
    logic                   http_len_closed;
    logic [HttpLenBits-1:0] http_seen;
    logic [7:0]             hunt_word [8];
    res_t                   due_results [$];
    int                     errors;

    function new();
      hunt_word = '{CH_D, CH_R, CH_V, CH_I, CH_TWO, CH_C, CH_R, CH_D};
      echo_on   = 1'b0;
      prev_rx   = 8'h00;
      i2c_armed = 1'b0;
      i2c_ph    = I2C_DISCARD;
      i2c_want  = 8'h00;
      i2c_seen  = 8'h00;
      close_http();
      errors    = 0;
    endfunction

    // Drops the HTTP query and clears its length and counters.
    function void close_http();
      http_armed      = 1'b0;
      http_ph         = HTTP_EMPTY;
      http_len        = '0;
      http_len_closed = 1'b0;
      http_seen       = '0;
    endfunction

    // Updates the state for one accepted input transfer and queues its result.
    function void accept_item(logic [1:0] cmd, logic [7:0] b, logic [7:0] len);
      res_t        r;
      logic        hit;
      logic [63:0] grown;
      r.kind       = KIND_ECHO;
      r.out_byte   = b;
      r.byte_index = '0;
      r.last       = 1'b0;
      hit          = 1'b0;
      if (cmd == CMD_ARM_I2C) begin
        i2c_armed = 1'b1;
        i2c_ph    = I2C_DISCARD;
        i2c_want  = len;
        i2c_seen  = 8'h00;
      end else if (cmd == CMD_ARM_HTTP) begin
        close_http();
        http_armed = 1'b1;
      end else if (cmd == CMD_BYTE) begin
        if (i2c_armed) begin
          // The I2C query owns the bytes whenever it is pending.
          case (i2c_ph)
            I2C_DATA: begin
              r.kind       = KIND_I2C;
              r.byte_index = ByteIdxW'(i2c_seen);
              i2c_seen     = i2c_seen + 8'd1;
              if (i2c_seen == i2c_want) begin
                r.last    = 1'b1;
                i2c_armed = 1'b0;
                i2c_ph    = I2C_DISCARD;
              end
              hit = 1'b1;
            end
            I2C_COLON: begin
              if (b == CH_COLON) begin
                i2c_seen = 8'h00;
                i2c_ph   = I2C_DATA;
              end else begin
                i2c_ph = I2C_DISCARD;
                hit    = echo_on;
              end
            end
            default: begin
              if (i2c_ph >= I2C_MATCH_D && i2c_ph <= I2C_MATCH_D2) begin
                if (b == hunt_word[3'(int'(i2c_ph) - 1)]) begin
                  // The R right after the D still goes out as an echo.
                  hit    = echo_on && (i2c_ph == I2C_MATCH_R);
                  i2c_ph = i2c_phase_t'(i2c_ph + 4'd1);
                end else begin
                  i2c_ph = I2C_DISCARD;
                  hit    = echo_on;
                end
              end else if (b == CH_PLUS && prev_rx != CH_T) begin
                i2c_ph = I2C_MATCH_D;
              end else begin
                i2c_ph = I2C_DISCARD;
                hit    = echo_on;
              end
            end
          endcase
        end else if (http_armed) begin
          case (http_ph)
            HTTP_EMPTY: begin
              if (b == CH_PLUS && prev_rx != CH_T) begin
                http_ph = HTTP_COLON;
              end else begin
                hit = echo_on;
              end
            end
            HTTP_COLON: begin
              if (b == CH_COLON) begin
                http_ph = HTTP_COMMA;
              end
            end
            HTTP_COMMA: begin
              if (b == CH_COMMA) begin
                if (http_len == '0) begin
                  close_http();
                end else begin
                  http_ph   = HTTP_DATA;
                  http_seen = '0;
                end
              end else if (!http_len_closed && b >= CH_ZERO && b <= CH_NINE) begin
                // Decimal length, saturating at the counter width.
                grown = 64'(http_len) * 64'd10 + 64'(b - CH_ZERO);
                if (grown > 64'(LenMax)) begin
                  grown = 64'(LenMax);
                end
                http_len = grown[HttpLenBits-1:0];
              end else begin
                http_len_closed = 1'b1;
              end
            end
            default: begin
              r.kind       = KIND_HTTP;
              r.byte_index = ByteIdxW'(http_seen);
              http_seen    = http_seen + HttpLenBits'(1);
              if (http_seen == http_len) begin
                r.last = 1'b1;
                close_http();
              end
              hit = 1'b1;
            end
          endcase
        end else begin
          hit = echo_on && (b != CH_FF);
        end
        if (hit) begin
          due_results.push_back(r);
        end
        prev_rx = b;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares one output transfer with the oldest expected result.
    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d byte %02h index %0d last %0b",
               got.kind, got.out_byte, got.byte_index, got.last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;       // [7:0] data_byte, [15:8] i2c_length
  logic [1:0]  in_tuser;       // [1:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;      // [7:0] out_byte, [31:8] byte_index
  logic [1:0]  out_tuser;      // [1:0] kind
  logic        out_tlast;

  deframer_scoreboard sb;
  logic quiet;
  int   items_sent;
  int   rx_hold;
  int   stuck_cycles;

  at_response_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: check each transfer, then stall for a random number of cycles.
  initial rx_hold = 0;
  always @(posedge clk) begin : rx_side
    res_t got;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
      got.kind       = kind_t'(out_tuser);
      got.out_byte   = out_tdata[7:0];
      got.byte_index = out_tdata[31:8];
      got.last       = out_tlast;
      sb.check_result(got);
      rx_hold = quiet ? 0 : $urandom_range(0, 3);
    end else if (rx_hold > 0) begin
      rx_hold--;
    end
    out_tready <= (rx_hold == 0);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
        (out_tvalid === 1'b1 && out_tready === 1'b1) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= StuckLimit) begin
      $error("no transfer in %0d cycles", StuckLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Filler text that can neither open a frame nor close a header.
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    c = rnd8();
    if (c == CH_PLUS || c == CH_COLON) begin
      c = CH_T;
    end
    return c;
  endfunction

  // Random byte weighted toward the characters the framing logic looks at.
  function automatic logic [7:0] odd_byte();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = CH_PLUS;
      1:       c = CH_T;
      2:       c = CH_FF;
      3:       c = CH_COLON;
      4:       c = CH_COMMA;
      5:       c = CH_D;
      6:       c = 8'(CH_ZERO + $urandom_range(0, 9));
      default: c = rnd8();
    endcase
    return c;
  endfunction

  // One input transfer after a random idle gap.
  task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic [7:0] len);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, b};
    in_tuser  <= cmd;
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
    sb.accept_item(cmd, b, len);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(CMD_BYTE, b, rnd8());
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Holds the input off until every result is out and the pipeline is empty.
  task automatic finish_pending();
    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_echo(logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.echo_on = value;
  endtask

  // Armed I2C read, mostly with a clean header and exactly the armed data.
  task automatic run_i2c_frame();
    logic [7:0] len;
    string      hdr;
    int         n;
    int         spot;
    logic       broken;
    case ($urandom_range(0, 19))
      0:       len = 8'd0;
      1:       len = 8'd255;
      2:       len = 8'($urandom_range(17, 254));
      default: len = 8'($urandom_range(1, 16));
    endcase
    hdr    = "+DRVI2CRD:";
    broken = ($urandom_range(0, 5) == 0);
    if (broken) begin
      spot = $urandom_range(0, hdr.len() - 1);
      hdr.putc(spot, 8'(hdr[spot] ^ (8'd1 << $urandom_range(0, 7))));
    end
    send_item(CMD_ARM_I2C, rnd8(), len);
    n = $urandom_range(0, 3);
    repeat (n) send_byte(text_byte());
    send_text(hdr);
    // A zero length wraps the counter, so the frame carries 256 bytes.
    n = broken ? $urandom_range(1, 4) : ((len == 8'd0) ? 256 : int'(len));
    repeat (n) send_byte(rnd8());
  endtask

  // Armed HTTP read with a decimal length between the colon and the comma.
  task automatic run_http_frame();
    int    len;
    string digits;
    int    n;
    logic  chopped;
    case ($urandom_range(0, 11))
      0: begin
        len    = 0;
        digits = ($urandom_range(0, 1) != 0) ? "" : "00";
      end
      1: begin
        len    = int'(LenMax);
        digits = "99999999";
      end
      2: begin
        len    = $urandom_range(1, 12);
        digits = $sformatf("%0dx%0d", len, $urandom_range(0, 9));
      end
      3: begin
        len    = $urandom_range(13, 300);
        digits = $sformatf("%0d", len);
      end
      default: begin
        len    = $urandom_range(1, 12);
        digits = $sformatf("%0d", len);
      end
    endcase
    chopped = ($urandom_range(0, 9) == 0);
    send_item(CMD_ARM_HTTP, rnd8(), rnd8());
    n = $urandom_range(0, 3);
    repeat (n) send_byte(text_byte());
    send_byte(CH_PLUS);
    n = $urandom_range(0, 4);
    repeat (n) send_byte(text_byte());
    send_byte(CH_COLON);
    send_text(digits);
    if (!chopped) begin
      send_byte(CH_COMMA);
      if (len == int'(LenMax)) begin
        // A saturated length is cut short by arming a fresh query.
        repeat (6) send_byte(rnd8());
        send_item(CMD_ARM_HTTP, rnd8(), rnd8());
      end else begin
        repeat (len) send_byte(rnd8());
      end
    end
  endtask

  // Short burst of stray bytes, arms and unknown commands.
  task automatic run_noise();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 15))
        0:       send_item(CMD_RESERVED, rnd8(), rnd8());
        1:       send_item(CMD_ARM_I2C, rnd8(), rnd8());
        2:       send_item(CMD_ARM_HTTP, rnd8(), rnd8());
        default: send_byte(odd_byte());
      endcase
    end
  endtask

  // Field extremes, the unknown command, a false start after T and both frame kinds.
  task automatic run_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_item(CMD_RESERVED, 8'hFF, 8'hFF);
    finish_pending();
    set_echo(1'b1);
    send_byte(8'h41);
    send_byte(CH_FF);
    send_item(CMD_RESERVED, 8'h00, 8'h00);
    send_item(CMD_ARM_I2C, 8'hFF, 8'd1);
    send_text("T++DRVI2CRD:");
    send_byte(8'hFF);
    // A zero HTTP length closes the frame at the comma.
    send_item(CMD_ARM_HTTP, 8'h00, 8'h00);
    send_text("+IPD:,");
    send_byte(8'h42);
  endtask

  // Main sequence: reset, directed part, then random phases with echo toggled.
  initial begin
    int base;
    int goal;
    int pick;
    sb         = new();
    quiet      = 1'b0;
    items_sent = 0;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_BYTE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    base = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      finish_pending();
      set_echo(logic'(ph % 2));
      goal = base + TotalItems * (ph + 1) / 4;
      while (items_sent < goal) begin
        quiet = ($urandom_range(0, 4) == 0);
        pick  = $urandom_range(0, 19);
        if (pick < 8) begin
          run_i2c_frame();
        end else if (pick < 15) begin
          run_http_frame();
        end else begin
          run_noise();
        end
      end
    end
    quiet = 1'b0;
    finish_pending();

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
